/* sv/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared sizes, codes, types and helpers for the allocator core.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_COUNT = 1024;

  localparam int ADDR_W    = 22;
  localparam int COUNT_W   = 23;
  localparam int ACTION_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Used map is held in words of WORD_BITS pages
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PAGE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int OFF_W      = $clog2(PAGE_BYTES + 1);
  localparam int SUM_W      = COUNT_W + 1;
  localparam int N_W        = SUM_W - PAGE_SHIFT;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END   = 2'd2;

  localparam logic [ADDR_W-1:0] KERNEL_END_RESET     = 22'd0;
  localparam logic [ADDR_W-1:0] RESERVED_START_RESET = 22'd983040;
  localparam logic [ADDR_W-1:0] RESERVED_END_RESET   = 22'd1048575;

  // How a word of the map is rewritten by the mask unit
  typedef enum logic [1:0] {
    MERGE_KEEP,
    MERGE_SET,
    MERGE_CLEAR
  } merge_t;

  // Two half-open page ranges [lo, hi)
  typedef struct packed {
    logic [PAGE_W-1:0] lo1;
    logic [PAGE_W-1:0] hi1;
    logic [PAGE_W-1:0] lo2;
    logic [PAGE_W-1:0] hi2;
  } page_ranges_t;

  // Saturate a page number at the page count
  function automatic logic [PAGE_W-1:0] clip_page(input logic [SUM_W-1:0] v);
    if (v > SUM_W'(PAGE_COUNT)) begin
      return PAGE_W'(PAGE_COUNT);
    end
    return v[PAGE_W-1:0];
  endfunction

  // Map word that holds a page
  function automatic logic [WADDR_W-1:0] word_of(input logic [PAGE_W-1:0] page);
    logic [PAGE_W-1:0] row;
    row = page >> BIT_W;
    return row[WADDR_W-1:0];
  endfunction

endpackage

/* sv/page_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator core
// One used bit per page plus a bump pointer, driven by a small sequencer.
// ----------------------------------------------------------------------------
// The used map lives in a RAM of 32-page words; every access goes through one
// shared mask unit, one word per read/write pair, so cost is set by the words
// touched. An allocate that fits the bump page takes a decode, one
// read-modify-write and a result. A first-fit allocate scans words from page 0:
// a word whose pages are all used or all free is judged whole, a mixed word is
// walked one page per cycle, then each word of the claimed run is rewritten.
// Free rewrites each word it spans and initialize every map word, each after
// a decode and before a hand-off. A failed allocate that fits the map by size
// walks the whole map. The next item is taken while a result still waits in
// the output register. Each map word has a valid flop cleared by reset, so an
// unwritten word reads as all free and there is no clearing pass after reset.
// Configuration writes land at once.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pba_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pba_pkg::ACTION_W-1:0]    action,
  input  logic [pba_pkg::ADDR_W-1:0]      address,
  input  logic [pba_pkg::COUNT_W-1:0]     byte_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pba_pkg::COUNT_W-1:0]     result_address,
  output logic                            status
);
  import pba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RANGE_RD,
    S_RANGE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_BIT,
    S_CLAIM,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [ADDR_W-1:0] kernel_end;
  logic [ADDR_W-1:0] reserved_start;
  logic [ADDR_W-1:0] reserved_end;

  // Bump pointer
  logic [PAGE_W-1:0] bump_page;
  logic [OFF_W-1:0]  bump_offset;

  // Item under work
  logic [ACTION_W-1:0] act;
  logic [ADDR_W-1:0]   addr_q;
  logic [COUNT_W-1:0]  size_q;
  logic [COUNT_W-1:0]  res_q;
  logic                status_q;

  // Sequencer state
  page_ranges_t      ranges;
  merge_t            merge_q;
  logic [WADDR_W-1:0] w;
  logic [WADDR_W-1:0] w_last;
  logic [N_W-1:0]    n_q;
  logic [PAGE_W-1:0] run;
  logic [PAGE_W-1:0] start_q;
  logic [BIT_W-1:0]  bit_idx;
  logic [WORD_BITS-1:0] shreg;

  // Map storage
  logic [WORD_COUNT-1:0] row_valid;
  logic                  rd_valid;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic [WORD_BITS-1:0]  rd_word;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  word_new;
  logic                  ram_re;
  logic                  ram_we;

  assign in_ready = (state == S_IDLE);
  assign ram_re   = (state == S_RANGE_RD) || (state == S_SCAN_RD);
  assign ram_we   = (state == S_RANGE_WR);
  // A word never written reads as all pages free
  assign rd_word  = rd_valid ? ram_rdata : '0;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w),
    .wdata (word_new),
    .re    (ram_re),
    .raddr (w),
    .rdata (ram_rdata)
  );

  pba_mask_unit u_mask_unit (
    .row      (w),
    .ranges   (ranges),
    .merge    (merge_q),
    .word_in  (rd_word),
    .mask     (mask),
    .word_out (word_new)
  );

  // --------------------------------------------------------------------------
  // Decode arithmetic
  // --------------------------------------------------------------------------
  logic [OFF_W-1:0]   fit_avail;
  logic               bump_fit;
  logic [COUNT_W-1:0] bump_addr;
  logic [SUM_W-1:0]   need_sum;
  logic [N_W-1:0]     n_pages;
  logic [SUM_W-1:0]   first_sum;
  logic [SUM_W-1:0]   stop_sum;
  logic [PAGE_W-1:0]  free_first;
  logic [PAGE_W-1:0]  free_stop;
  logic [PAGE_W-1:0]  kern_last;
  logic [PAGE_W-1:0]  resv_lo;
  logic [PAGE_W-1:0]  resv_hi;
  logic               resv_ok;

  always_comb begin
    fit_avail = OFF_W'(PAGE_BYTES) - bump_offset;
    bump_fit  = (bump_page < PAGE_W'(PAGE_COUNT)) &&
                (bump_offset <= OFF_W'(PAGE_BYTES)) &&
                (COUNT_W'(fit_avail) >= size_q);
    bump_addr = COUNT_W'({bump_page, {PAGE_SHIFT{1'b0}}}) + COUNT_W'(bump_offset);

    // Pages needed, rounded up
    need_sum = SUM_W'(size_q) + SUM_W'(PAGE_BYTES - 1);
    n_pages  = need_sum[SUM_W-1:PAGE_SHIFT];

    // Free only whole pages inside the byte range
    first_sum  = SUM_W'(addr_q) + SUM_W'(PAGE_BYTES - 1);
    stop_sum   = SUM_W'(addr_q) + SUM_W'(size_q);
    free_first = clip_page(SUM_W'(first_sum[SUM_W-1:PAGE_SHIFT]));
    free_stop  = clip_page(SUM_W'(stop_sum[SUM_W-1:PAGE_SHIFT]));

    kern_last = clip_page(SUM_W'(kernel_end >> PAGE_SHIFT) + SUM_W'(1));
    resv_lo   = clip_page(SUM_W'(reserved_start >> PAGE_SHIFT));
    resv_hi   = clip_page(SUM_W'(reserved_end >> PAGE_SHIFT) + SUM_W'(1));
    resv_ok   = (reserved_start <= reserved_end);
  end

  // --------------------------------------------------------------------------
  // Scan arithmetic
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] free_bits;
  logic                 all_free;
  logic                 none_free;
  logic [PAGE_W:0]      run_word;
  logic [PAGE_W-1:0]    row_base;
  logic [PAGE_W-1:0]    start_word;
  logic [PAGE_W-1:0]    page_bit;
  logic [PAGE_W-1:0]    run_inc;
  logic [PAGE_W-1:0]    start_bit;
  logic                 last_row;
  logic [PAGE_W-1:0]    claim_hi;
  logic [PAGE_SHIFT-1:0] rem;
  logic [OFF_W-1:0]     claim_off;

  always_comb begin
    // During the scan the mask covers the pages that exist
    free_bits  = ~rd_word & mask;
    all_free   = &free_bits;
    none_free  = (free_bits == '0);
    run_word   = (PAGE_W + 1)'(run) + (PAGE_W + 1)'(WORD_BITS);
    row_base   = PAGE_W'({w, {BIT_W{1'b0}}});
    start_word = row_base - run;
    page_bit   = PAGE_W'({w, bit_idx});
    run_inc    = run + PAGE_W'(1);
    start_bit  = page_bit + PAGE_W'(1) - PAGE_W'(n_q);
    last_row   = (w == WADDR_W'(WORD_COUNT - 1));

    claim_hi  = start_q + PAGE_W'(n_q);
    rem       = size_q[PAGE_SHIFT-1:0];
    claim_off = (rem == '0) ? OFF_W'(PAGE_BYTES) : OFF_W'(rem);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      bump_page      <= '0;
      bump_offset    <= '0;
      row_valid      <= '0;
      kernel_end     <= KERNEL_END_RESET;
      reserved_start <= RESERVED_START_RESET;
      reserved_end   <= RESERVED_END_RESET;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_KERNEL_END:     kernel_end     <= cfg_data;
          CFG_RESERVED_START: reserved_start <= cfg_data;
          CFG_RESERVED_END:   reserved_end   <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken; the result state refills it itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= action;
            addr_q     <= address;
            size_q     <= byte_count;
            res_q      <= '0;
            status_q   <= 1'b0;
            ranges.lo2 <= '0;
            ranges.hi2 <= '0;
            state      <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (act)
            ACT_ALLOC: begin
              if (bump_fit) begin
                // Serve from the rest of the bump page
                res_q       <= bump_addr;
                bump_offset <= bump_offset + OFF_W'(size_q);
                ranges.lo1  <= bump_page;
                ranges.hi1  <= bump_page + PAGE_W'(1);
                merge_q     <= MERGE_SET;
                w           <= word_of(bump_page);
                w_last      <= word_of(bump_page);
                state       <= S_RANGE_RD;
              end else if (n_pages == '0) begin
                state <= S_DONE;
              end else if (n_pages > N_W'(PAGE_COUNT)) begin
                status_q <= 1'b1;
                state    <= S_DONE;
              end else begin
                n_q        <= n_pages;
                run        <= '0;
                w          <= '0;
                ranges.lo1 <= '0;
                ranges.hi1 <= PAGE_W'(PAGE_COUNT);
                merge_q    <= MERGE_KEEP;
                state      <= S_SCAN_RD;
              end
            end
            ACT_FREE: begin
              if (free_first < free_stop) begin
                ranges.lo1 <= free_first;
                ranges.hi1 <= free_stop;
                merge_q    <= MERGE_CLEAR;
                w          <= word_of(free_first);
                w_last     <= word_of(free_stop - PAGE_W'(1));
                state      <= S_RANGE_RD;
              end else begin
                state <= S_DONE;
              end
            end
            ACT_INIT: begin
              // Kernel pages and the reserved range in one sweep
              ranges.lo1  <= '0;
              ranges.hi1  <= kern_last;
              ranges.lo2  <= resv_ok ? resv_lo : '0;
              ranges.hi2  <= resv_ok ? resv_hi : '0;
              merge_q     <= MERGE_SET;
              bump_page   <= kern_last;
              bump_offset <= OFF_W'(PAGE_BYTES);
              w           <= '0;
              w_last      <= WADDR_W'(WORD_COUNT - 1);
              state       <= S_RANGE_RD;
            end
            default: state <= S_DONE;
          endcase
        end

        S_RANGE_RD: begin
          rd_valid <= row_valid[w];
          state    <= S_RANGE_WR;
        end

        S_RANGE_WR: begin
          row_valid[w] <= 1'b1;
          if (w == w_last) begin
            state <= S_DONE;
          end else begin
            w     <= w + WADDR_W'(1);
            state <= S_RANGE_RD;
          end
        end

        S_SCAN_RD: begin
          rd_valid <= row_valid[w];
          state    <= S_SCAN_CHK;
        end

        S_SCAN_CHK: begin
          if (all_free) begin
            if (SUM_W'(run_word) >= SUM_W'(n_q)) begin
              start_q <= start_word;
              state   <= S_CLAIM;
            end else begin
              run <= run_word[PAGE_W-1:0];
              if (last_row) begin
                status_q <= 1'b1;
                state    <= S_DONE;
              end else begin
                w     <= w + WADDR_W'(1);
                state <= S_SCAN_RD;
              end
            end
          end else if (none_free) begin
            run <= '0;
            if (last_row) begin
              status_q <= 1'b1;
              state    <= S_DONE;
            end else begin
              w     <= w + WADDR_W'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            // Mixed word: walk it one page a cycle
            shreg   <= free_bits;
            bit_idx <= '0;
            state   <= S_SCAN_BIT;
          end
        end

        S_SCAN_BIT: begin
          if (shreg[0] && (SUM_W'(run_inc) >= SUM_W'(n_q))) begin
            start_q <= start_bit;
            state   <= S_CLAIM;
          end else begin
            run     <= shreg[0] ? run_inc : '0;
            shreg   <= shreg >> 1;
            bit_idx <= bit_idx + BIT_W'(1);
            if (bit_idx == BIT_W'(WORD_BITS - 1)) begin
              if (last_row) begin
                status_q <= 1'b1;
                state    <= S_DONE;
              end else begin
                w     <= w + WADDR_W'(1);
                state <= S_SCAN_RD;
              end
            end
          end
        end

        S_CLAIM: begin
          // Mark the run and move the bump pointer to its last page
          ranges.lo1  <= start_q;
          ranges.hi1  <= claim_hi;
          merge_q     <= MERGE_SET;
          res_q       <= COUNT_W'({start_q, {PAGE_SHIFT{1'b0}}});
          bump_page   <= claim_hi - PAGE_W'(1);
          bump_offset <= claim_off;
          w           <= word_of(start_q);
          w_last      <= word_of(claim_hi - PAGE_W'(1));
          state       <= S_RANGE_RD;
        end

        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            result_address <= res_q;
            status         <= status_q;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/pba_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pba_mask_unit.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator mask unit
// Builds the page mask of one map word from two page ranges and merges it.
// ----------------------------------------------------------------------------
module pba_mask_unit (
  input  logic [pba_pkg::WADDR_W-1:0]   row,
  input  pba_pkg::page_ranges_t         ranges,
  input  pba_pkg::merge_t               merge,
  input  logic [pba_pkg::WORD_BITS-1:0] word_in,
  output logic [pba_pkg::WORD_BITS-1:0] mask,
  output logic [pba_pkg::WORD_BITS-1:0] word_out
);
  import pba_pkg::*;

  for (genvar b = 0; b < WORD_BITS; b++) begin : g_bit
    logic [PAGE_W-1:0] page;
    assign page = PAGE_W'({row, BIT_W'(b)});
    assign mask[b] = ((page >= ranges.lo1) && (page < ranges.hi1)) ||
                     ((page >= ranges.lo2) && (page < ranges.hi2));
  end

  always_comb begin
    case (merge)
      MERGE_SET:   word_out = word_in | mask;
      MERGE_CLEAR: word_out = word_in & ~mask;
      default:     word_out = word_in;
    endcase
  end

endmodule

/* sv/pba_checker.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Port-level checks on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
module pba_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pba_pkg::COUNT_W-1:0]     result_address,
  input logic                            status
);
  import pba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_address) && $stable(status))
    else $error("result item changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result_address == '0)
    else $error("failed allocate returned a nonzero address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item was worked");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("new result without return to idle");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset left a result or a busy input");

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator core testbench
// Drives allocate, free, initialize and undecoded items through the valid/ready
// input, predicts every reply from a behavioral copy of the page map and bump
// pointer, checks each reply against it or a directed row's own, field by field.
// A directed table comes first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  // Action 3 is not decoded by the block; it must answer with zeros
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_ROOM = 1'b1;

  // Directed rows either carry their own reply or defer to the predictor
  localparam logic CHECK_FIXED = 1'b1;
  localparam logic CHECK_MODEL = 1'b0;

  localparam int MAP_BYTES     = PAGE_BYTES * PAGE_COUNT;
  localparam int ADDR_MAX      = MAP_BYTES - 1;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 75;
  localparam int LONG_STALL    = 400;
  localparam int TAIL_CYCLES   = 200;
  localparam int DIRECTED_ROWS = 28;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [1:0]           code;      // action for items, register index for writes
    logic [ADDR_W-1:0]    addr;      // item address or register value
    logic [COUNT_W-1:0]   count;
    logic                 check;
    logic [COUNT_W-1:0]   exp_addr;
    logic                 exp_status;
  } stim_row_t;

  typedef struct packed {
    logic [COUNT_W-1:0] addr;
    logic               status;
  } alloc_reply_t;

  typedef struct packed {
    logic [COUNT_W-1:0] addr;
    logic [COUNT_W-1:0] size;
  } live_block_t;

  // --------------------------------------------------------------------------
  // DUT signals, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk              = 1'b0;
  logic                 rst              = 1'b1;
  logic                 cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = CFG_KERNEL_END;
  logic [ADDR_W-1:0]    cfg_data         = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action           = ACT_ALLOC;
  logic [ADDR_W-1:0]    address          = '0;
  logic [COUNT_W-1:0]   byte_count       = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [COUNT_W-1:0]   result_address;
  logic                 status;

  page_bitmap_allocator_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .address          (address),
    .byte_count       (byte_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_address   (result_address),
    .status           (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted allocator state: one bit per page, bump pointer, registers
  // --------------------------------------------------------------------------
  bit                 page_taken [PAGE_COUNT];
  longint unsigned    bump_pg  = 0;
  longint unsigned    bump_off = 0;
  logic [ADDR_W-1:0]  kernel_end_reg     = KERNEL_END_RESET;
  logic [ADDR_W-1:0]  reserved_start_reg = RESERVED_START_RESET;
  logic [ADDR_W-1:0]  reserved_end_reg   = RESERVED_END_RESET;

  alloc_reply_t pending_replies [$];
  live_block_t  live_blocks [$];
  int           failures     = 0;
  int           replies_seen = 0;
  bit           steady       = 1'b0;

  // Set or clear pages [first, stop), with stop clipped to the map
  function automatic void mark_pages(longint unsigned first, longint unsigned stop, bit v);
    longint unsigned p;
    if (stop > PAGE_COUNT) begin
      stop = PAGE_COUNT;
    end
    for (p = first; p < stop; p++) begin
      page_taken[p] = v;
    end
  endfunction

  // Advance the predicted state by one item and return its reply
  function automatic alloc_reply_t apply_page_action(logic [ACTION_W-1:0] act,
                                                     logic [ADDR_W-1:0]   addr,
                                                     logic [COUNT_W-1:0]  cnt);
    alloc_reply_t    r;
    longint unsigned sz;
    longint unsigned a;
    longint unsigned pages;
    longint unsigned run;
    longint unsigned start_pg;
    longint unsigned p;
    longint unsigned last;
    bit              found;
    r.addr   = '0;
    r.status = ST_OK;
    sz = 64'(cnt);
    a  = 64'(addr);
    case (act)
      ACT_ALLOC: begin
        if (bump_pg < PAGE_COUNT && bump_off <= PAGE_BYTES &&
            PAGE_BYTES - bump_off >= sz) begin
          // Serve from the tail of the bump page
          r.addr   = COUNT_W'(bump_pg * PAGE_BYTES + bump_off);
          bump_off = bump_off + sz;
          page_taken[bump_pg] = 1'b1;
        end else begin
          pages = (sz + PAGE_BYTES - 1) / PAGE_BYTES;
          if (pages > PAGE_COUNT) begin
            r.status = ST_NO_ROOM;
          end else if (pages != 0) begin
            // First fit over the whole map, last page included
            run      = 0;
            start_pg = 0;
            found    = 1'b0;
            for (p = 0; p < PAGE_COUNT && !found; p++) begin
              if (page_taken[p]) begin
                run = 0;
              end else begin
                run++;
                if (run >= pages) begin
                  start_pg = p + 1 - pages;
                  found    = 1'b1;
                end
              end
            end
            if (found) begin
              mark_pages(start_pg, start_pg + pages, 1'b1);
              r.addr   = COUNT_W'(start_pg * PAGE_BYTES);
              bump_pg  = start_pg + pages - 1;
              bump_off = (sz % PAGE_BYTES == 0) ? PAGE_BYTES : sz % PAGE_BYTES;
            end else begin
              r.status = ST_NO_ROOM;
            end
          end
        end
      end
      ACT_FREE: begin
        // Only whole pages inside the byte range are released
        mark_pages((a + PAGE_BYTES - 1) / PAGE_BYTES, (a + sz) / PAGE_BYTES, 1'b0);
      end
      ACT_INIT: begin
        last = longint'(kernel_end_reg) / PAGE_BYTES + 1;
        mark_pages(0, last, 1'b1);
        bump_pg  = (last > PAGE_COUNT) ? PAGE_COUNT : last;
        bump_off = PAGE_BYTES;
        if (reserved_start_reg <= reserved_end_reg) begin
          mark_pages(longint'(reserved_start_reg) / PAGE_BYTES,
                     longint'(reserved_end_reg) / PAGE_BYTES + 1, 1'b1);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one item, hold it until taken, then record what it should return
  task automatic offer_item(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic [COUNT_W-1:0] cnt, input logic check,
                            input alloc_reply_t fixed_reply, output alloc_reply_t reply);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    address    <= addr;
    byte_count <= cnt;
    do @(posedge clk); while (!in_ready);
    // Item taken at this edge: step the predictor in acceptance order
    reply = apply_page_action(act, addr, cnt);
    pending_replies.push_back(check ? fixed_reply : reply);
  endtask

  // Drop valid and hold until every predicted reply has been checked
  task automatic wait_all_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Write one register; the extra edge keeps back-to-back writes clean
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
    case (idx)
      CFG_KERNEL_END:     kernel_end_reg     = value;
      CFG_RESERVED_START: reserved_start_reg = value;
      CFG_RESERVED_END:   reserved_end_reg   = value;
      default: begin
      end
    endcase
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Directed table; hand-written replies only where they are obvious
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // zero bytes from a fresh map: served at page 0 offset 0
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd0,       CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd100,     CHECK_FIXED, 23'd0,       ST_OK},
    // exactly fills the rest of the bump page
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd3996,    CHECK_FIXED, 23'd100,     ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd1,       CHECK_FIXED, 23'd4096,    ST_OK},
    // whole map while pages are taken: no room
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd4194304, CHECK_FIXED, 23'd0,       ST_NO_ROOM},
    '{ROW_ITEM, ACT_UNKNOWN, 22'd4194303, 23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_FREE,    22'd0,       23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    // whole map when free, run ends on the last page
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    // zero bytes at the very end of the last page
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd0,       CHECK_FIXED, 23'd4194304, ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd1,       CHECK_FIXED, 23'd0,       ST_NO_ROOM},
    // free range that holds no whole page of the map
    '{ROW_ITEM, ACT_FREE,    22'd4194303, 23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_FREE,    22'd4190208, 23'd4096,    CHECK_FIXED, 23'd0,       ST_OK},
    // the last page alone is found by first fit
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd4096,    CHECK_FIXED, 23'd4190208, ST_OK},
    '{ROW_ITEM, ACT_INIT,    22'd4194303, 23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_FREE,    22'd0,       23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_INIT,    22'd0,       23'd0,       CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd5000,    CHECK_MODEL, 23'd0,       ST_OK},
    // run must skip over the reserved high range
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd983040,  CHECK_MODEL, 23'd0,       ST_OK},
    '{ROW_CFG,  CFG_KERNEL_END,     22'd4194303, 23'd0, CHECK_MODEL, 23'd0,      ST_OK},
    // kernel covers the map: bump page saturates past the last page
    '{ROW_ITEM, ACT_INIT,    22'd0,       23'd0,       CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd0,       CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd1,       CHECK_FIXED, 23'd0,       ST_NO_ROOM},
    // reserved start above its end reserves nothing
    '{ROW_CFG,  CFG_RESERVED_START, 22'd4194303, 23'd0, CHECK_MODEL, 23'd0,      ST_OK},
    '{ROW_CFG,  CFG_RESERVED_END,   22'd0,       23'd0, CHECK_MODEL, 23'd0,      ST_OK},
    '{ROW_CFG,  CFG_KERNEL_END,     22'd0,       23'd0, CHECK_MODEL, 23'd0,      ST_OK},
    '{ROW_ITEM, ACT_FREE,    22'd0,       23'd4194304, CHECK_FIXED, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_INIT,    22'd0,       23'd0,       CHECK_MODEL, 23'd0,       ST_OK},
    '{ROW_ITEM, ACT_ALLOC,   22'd0,       23'd4190208, CHECK_MODEL, 23'd0,       ST_OK}
  };

  initial begin : stimulus
    logic [ADDR_W-1:0]   kern_set  [PHASES];
    logic [ADDR_W-1:0]   rsv_lo_set[PHASES];
    logic [ADDR_W-1:0]   rsv_hi_set[PHASES];
    alloc_reply_t        fixed_reply;
    alloc_reply_t        got;
    live_block_t         blk;
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  cnt;
    longint unsigned     span;
    int                  r;
    int                  s;
    int                  k;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; register rows only once the block is idle
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_all_replies();
        write_reg(directed_rows[i].code, directed_rows[i].addr);
      end else begin
        fixed_reply.addr   = directed_rows[i].exp_addr;
        fixed_reply.status = directed_rows[i].exp_status;
        offer_item(directed_rows[i].code, directed_rows[i].addr, directed_rows[i].count,
                   directed_rows[i].check, fixed_reply, got);
      end
    end

    // Register settings per phase: reset values, extremes, random mixes
    kern_set[0] = KERNEL_END_RESET;  rsv_lo_set[0] = RESERVED_START_RESET;
    rsv_hi_set[0] = RESERVED_END_RESET;
    kern_set[1] = 22'd4194303;       rsv_lo_set[1] = 22'd0;       rsv_hi_set[1] = 22'd4194303;
    kern_set[2] = 22'd0;             rsv_lo_set[2] = 22'd0;       rsv_hi_set[2] = 22'd0;
    kern_set[3] = ADDR_W'($urandom_range(0, 1048575));
    rsv_lo_set[3] = ADDR_W'($urandom_range(0, ADDR_MAX));
    rsv_hi_set[3] = ADDR_W'($urandom_range(0, ADDR_MAX));
    kern_set[4] = 22'd65535;         rsv_lo_set[4] = 22'd4190208; rsv_hi_set[4] = 22'd4194303;
    kern_set[5] = ADDR_W'($urandom_range(0, 262143));
    rsv_lo_set[5] = ADDR_W'($urandom_range(0, ADDR_MAX));
    rsv_hi_set[5] = ADDR_W'($urandom_range(0, ADDR_MAX));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_all_replies();
      write_reg(CFG_KERNEL_END, kern_set[ph]);
      write_reg(CFG_RESERVED_START, rsv_lo_set[ph]);
      write_reg(CFG_RESERVED_END, rsv_hi_set[ph]);
      live_blocks.delete();

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady = (ph % 2 == 1) && (i < 30);
        addr = ADDR_W'($urandom_range(0, ADDR_MAX));
        cnt  = COUNT_W'($urandom_range(0, MAP_BYTES));
        r    = $urandom_range(0, 99);
        if (i == 0 || (r >= 88 && r < 93)) begin
          // Each phase opens, and now and then goes on, by reserving kernel and reserved-range pages
          act = ACT_INIT;
        end else if (r < 50) begin
          act = ACT_ALLOC;
          s   = $urandom_range(0, 99);
          if (s < 30) begin
            cnt = COUNT_W'($urandom_range(1, PAGE_BYTES));
          end else if (s < 55) begin
            cnt = COUNT_W'($urandom_range(1, 16 * PAGE_BYTES));
          end else if (s < 70) begin
            cnt = COUNT_W'(PAGE_BYTES * $urandom_range(1, 8));
          end else if (s < 80) begin
            cnt = COUNT_W'($urandom_range(0, MAP_BYTES));
          end else if (s < 85) begin
            cnt = '0;
          end else begin
            cnt = COUNT_W'($urandom_range(PAGE_BYTES + 1, 64 * PAGE_BYTES));
          end
        end else if (r < 75 && live_blocks.size() != 0) begin
          // Give back a block handed out earlier, sometimes widened to whole pages
          act = ACT_FREE;
          k   = $urandom_range(0, live_blocks.size() - 1);
          blk = live_blocks[k];
          live_blocks.delete(k);
          addr = blk.addr[ADDR_W-1:0];
          cnt  = blk.size;
          if ($urandom_range(0, 1) == 1) begin
            span = (longint'(blk.addr) % PAGE_BYTES) + blk.size + PAGE_BYTES - 1;
            span = (span / PAGE_BYTES) * PAGE_BYTES;
            addr = blk.addr[ADDR_W-1:0] & ~ADDR_W'(PAGE_BYTES - 1);
            cnt  = (span > MAP_BYTES) ? COUNT_W'(MAP_BYTES) : COUNT_W'(span);
          end
        end else if (r < 85) begin
          act = ACT_FREE;
          if ($urandom_range(0, 1) == 1) begin
            cnt = COUNT_W'($urandom_range(0, 16 * PAGE_BYTES));
          end
        end else if (r < 88) begin
          act  = ACT_FREE;
          addr = '0;
          cnt  = COUNT_W'(MAP_BYTES);
        end else begin
          act = ACT_UNKNOWN;
        end

        offer_item(act, addr, cnt, CHECK_MODEL, fixed_reply, got);
        if (act == ACT_ALLOC && got.status == ST_OK && cnt != 0 &&
            got.addr < COUNT_W'(MAP_BYTES)) begin
          blk.addr = got.addr;
          blk.size = cnt;
          live_blocks.push_back(blk);
          if (live_blocks.size() > 64) begin
            void'(live_blocks.pop_front());
          end
        end

        // Now and then hold the sender until the block has drained
        if ($urandom_range(0, 99) < 2) begin
          wait_all_replies();
        end
      end
    end
    steady = 1'b0;

    wait_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random back-pressure plus two long hold-offs
  // --------------------------------------------------------------------------
  initial begin : drive_out_ready
    int hold;
    int burst;
    int stall_idx;
    stall_idx = 0;
    while (rst) @(posedge clk);
    forever begin
      // Hold off long enough for the block to fill and stall its input
      if ((stall_idx == 0 && replies_seen >= 80) || (stall_idx == 1 && replies_seen >= 260)) begin
        hold = LONG_STALL;
        stall_idx++;
      end else begin
        hold = gap_len();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      burst = $urandom_range(1, 40);
      repeat (burst) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Reply checker: compare each taken reply with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no item pending: result_address %0d status %0d",
               result_address, status);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        if (result_address !== want.addr) begin
          $error("result_address expected %0d actual %0d", want.addr, result_address);
          failures++;
        end
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          failures++;
        end
      end
      replies_seen++;
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
